// ===== rtl/bsk_pkg.sv =====
// Package for the battery SOC Kalman estimator: shared widths, constants,
// the sequencer state type and the control structs for the serial units.
// No dependencies.
package bsk_pkg;

	// Fixed-point formats.
	localparam int SOC_FRAC_BITS = 16;
	localparam int SOC_W         = SOC_FRAC_BITS + 1;
	localparam int SOCP_W        = 34;

	// Serial divider and multiplier sizes.
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 40;
	localparam int DIV_CNT_W = 7;
	localparam int MUL_A_W   = 33;
	localparam int MUL_B_W   = 32;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = 6;

	// Model constants.
	localparam logic [11:0] OCV_BASE_MV   = 12'd3000;
	localparam logic [9:0]  OCV_SLOPE_MV  = 10'd500;
	localparam logic [21:0] MS_PER_HOUR_K = 22'd3600000;
	localparam logic [9:0]  MILLI_DIV     = 10'd1000;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PROC_VAR = 3'd0,
		REG_OBS_VAR  = 3'd1,
		REG_INIT_SOC = 3'd2,
		REG_INIT_COV = 3'd3,
		REG_PERIOD   = 3'd4,
		REG_CAPACITY = 3'd5,
		REG_RESIST   = 3'd6
	} bsk_reg_t;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DELTA  = 9'b000000010,
		S_IR     = 9'b000000100,
		S_INNOV  = 9'b000001000,
		S_GAIN   = 9'b000010000,
		S_CMUL   = 9'b000100000,
		S_CDIV   = 9'b001000000,
		S_PMUL   = 9'b010000000,
		S_FINISH = 9'b100000000
	} bsk_state_t;

	// Request to the serial divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} bsk_div_ctl_t;

	// Status of a serial unit.
	typedef struct packed {
		logic busy;
		logic done;
	} bsk_unit_sts_t;

endpackage

// ===== rtl/bsk_if.sv =====
// Valid/ready channel interfaces for the estimator's sample and result words.
// No dependencies.
interface bsk_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] current_ma;
	logic [15:0]        voltage_mv;

	modport source(output valid, output current_ma, output voltage_mv, input ready);
	modport sink(input valid, input current_ma, input voltage_mv, output ready);
endinterface

interface bsk_out_if;
	logic               valid;
	logic               ready;
	logic [16:0]        estimated_soc;
	logic [31:0]        estimated_cov;
	logic signed [17:0] innovation_mv;
	logic               soc_clamped;

	modport source(output valid, output estimated_soc, output estimated_cov,
		output innovation_mv, output soc_clamped, input ready);
	modport sink(input valid, input estimated_soc, input estimated_cov,
		input innovation_mv, input soc_clamped, output ready);
endinterface

// ===== rtl/bsk_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bsk_pkg.
module bsk_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsk_pkg::bsk_div_ctl_t          ctl,
	input  logic [bsk_pkg::DIV_NUM_W-1:0]  num,
	input  logic [bsk_pkg::DIV_DEN_W-1:0]  den,
	output bsk_pkg::bsk_unit_sts_t         sts,
	output logic [bsk_pkg::DIV_NUM_W-1:0]  quo
);
	import bsk_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// Bring down the next numerator bit and try the subtraction.
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= ctl.iters;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: numerator shifts out, quotient shifts in.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

// ===== rtl/bsk_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on bsk_pkg.
module bsk_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bsk_pkg::MUL_A_W-1:0]   a,
	input  logic [bsk_pkg::MUL_B_W-1:0]   b,
	output bsk_pkg::bsk_unit_sts_t        sts,
	output logic [bsk_pkg::MUL_P_W-1:0]   prod
);
	import bsk_pkg::*;

	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [MUL_A_W-1:0]   a_q;
	logic [MUL_A_W-1:0]   hi_q;
	logic [MUL_B_W-1:0]   lo_q;
	logic [MUL_A_W:0]     sum;

	// Add the multiplicand when the low bit is set.
	assign sum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : {MUL_A_W{1'b0}})};

	// Sequencing over all multiplier bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= MUL_CNT_W'(MUL_B_W - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Product register shifts right as partial sums come in.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign prod     = {hi_q, lo_q};

endmodule

// ===== rtl/battery_soc_kalman_estimator_core.sv =====
// Scalar Kalman SOC estimator: one current/voltage sample in, one estimate out.
// Each sample runs divisions of 48, 32, 64 and 50 bits and two 32-bit multiplies, on one
// serial divider and one serial multiplier. A zero capacity skips the 48-bit division; a zero
// predicted covariance together with a zero observation variance skips the 64-bit division.
// One word is in work at a time: a new sample is taken only after the last result is registered.
// Reset loads the configuration defaults and the state from them; no clearing pass.
module battery_soc_kalman_estimator_core (
	input  logic        clk,
	input  logic        arst_n,
	bsk_in_if.sink      in_ch,
	bsk_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import bsk_pkg::*;

	// Configuration and filter state.
	logic [31:0]      proc_var_q, obs_var_q, init_cov_q, cov_q;
	logic [SOC_W-1:0] init_soc_q, soc_q;
	logic [15:0]      period_q, capacity_q, resist_q;

	bsk_state_t state_q;
	logic       go_q;

	// Per-sample working registers.
	logic                     neg_q;
	logic [15:0]              volt_q;
	logic [31:0]              mdt_q, mrm_q, pp_q;
	logic [37:0]              den_q;
	logic signed [SOCP_W-1:0] socp_q;
	logic [23:0]              ir_q;
	logic [17:0]              y_q;
	logic [34:0]              s4_q;
	logic [MUL_A_W-1:0]       g_q;
	logic [SOC_W-1:0]         soc_n_q;
	logic                     clamp_q;
	logic [31:0]              pnew_q;

	// Result word registers.
	logic             out_valid_q;
	logic [SOC_W-1:0] out_soc_q;
	logic [31:0]      out_cov_q;
	logic [17:0]      out_y_q;
	logic             out_clamp_q;

	logic        accept, finish;
	logic [15:0] abs_cur;
	logic [32:0] pp_sum;

	bsk_div_ctl_t             div_ctl;
	bsk_unit_sts_t            div_sts, mul_sts;
	logic [DIV_NUM_W-1:0]     div_num, div_quo;
	logic [DIV_DEN_W-1:0]     div_den;
	logic                     mul_start;
	logic [MUL_A_W-1:0]       mul_a;
	logic [MUL_B_W-1:0]       mul_b;
	logic [MUL_P_W-1:0]       mul_prod;

	logic [43:0]              slope, slope_mag, slope_rnd, pred, y_full;
	logic [17:0]              y_sat, y_mag;
	logic [34:0]              s4;
	logic [SOCP_W-1:0]        soc_sum;
	logic [MUL_P_W:0]         p_rnd;
	logic [49:0]              corr_num;
	logic [47:0]              delta_num;

	assign accept = in_ch.valid && in_ch.ready;
	assign finish = (state_q == S_FINISH) && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = (state_q == S_IDLE);

	// Sample-time products and predicted covariance.
	assign abs_cur = in_ch.current_ma[15] ? 16'(-in_ch.current_ma) : in_ch.current_ma;
	assign pp_sum  = {1'b0, cov_q} + {1'b0, proc_var_q};

	// Innovation: measured minus 3000 + round(500*socp/2^F) + IR drop.
	assign slope     = 44'({{(44 - SOCP_W){socp_q[SOCP_W-1]}}, socp_q} * 44'd500);
	assign slope_mag = slope[43] ? 44'(-slope) : slope;
	assign slope_rnd = 44'((slope_mag + (44'd1 << (SOC_FRAC_BITS - 1))) >> SOC_FRAC_BITS);
	assign pred      = 44'({32'd0, OCV_BASE_MV})
		+ (slope[43] ? 44'(-slope_rnd) : slope_rnd)
		+ {{20{ir_q[23]}}, ir_q};
	assign y_full    = {28'd0, volt_q} - pred;

	always_comb begin
		if ($signed(y_full) > 44'sd131071) begin
			y_sat = 18'h1FFFF;
		end else if ($signed(y_full) < -44'sd131072) begin
			y_sat = 18'h20000;
		end else begin
			y_sat = y_full[17:0];
		end
	end

	assign s4    = {3'd0, pp_q} + {1'b0, obs_var_q, 2'b00};
	assign y_mag = y_q[17] ? 18'(-y_q) : y_q;

	// Divider operands for each division step, numerators left-aligned.
	assign delta_num = {mdt_q, 16'd0} + {11'd0, den_q[37:1]};
	assign corr_num  = mul_prod[49:0] + (50'd250 << (32 - SOC_FRAC_BITS));

	always_comb begin
		div_num     = '0;
		div_den     = '0;
		div_ctl     = '0;
		div_ctl.start = go_q && (state_q == S_DELTA || state_q == S_IR
			|| state_q == S_GAIN || state_q == S_CDIV);
		case (state_q)
			S_DELTA: begin
				div_num       = {delta_num, 16'd0};
				div_den       = {2'd0, den_q};
				div_ctl.iters = DIV_CNT_W'(48);
			end
			S_IR: begin
				div_num       = {mrm_q + 32'd500, 32'd0};
				div_den       = {30'd0, MILLI_DIV};
				div_ctl.iters = DIV_CNT_W'(32);
			end
			S_GAIN: begin
				div_num       = {pp_q, 32'd0};
				div_den       = {5'd0, s4_q};
				div_ctl.iters = DIV_CNT_W'(64);
			end
			S_CDIV: begin
				div_num       = {corr_num, 14'd0};
				div_den       = DIV_DEN_W'({30'd0, OCV_SLOPE_MV} << (32 - SOC_FRAC_BITS));
				div_ctl.iters = DIV_CNT_W'(50);
			end
			default: begin
				div_ctl.iters = '0;
			end
		endcase
	end

	// Multiplier operands: gain times innovation, then (1 - gain) times covariance.
	assign mul_start = go_q && (state_q == S_CMUL || state_q == S_PMUL);
	assign mul_a     = (state_q == S_PMUL) ? 33'(34'h1_0000_0000 - {1'b0, g_q}) : g_q;
	assign mul_b     = (state_q == S_PMUL) ? pp_q : {14'd0, y_mag};

	// Corrected SOC before the clamp, and rounded new covariance.
	assign soc_sum = y_q[17] ? socp_q - {2'd0, div_quo[31:0]}
		: socp_q + {2'd0, div_quo[31:0]};
	assign p_rnd   = {1'b0, mul_prod} + (66'd1 << 31);

	bsk_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(div_num), .den(div_den),
		.sts(div_sts), .quo(div_quo)
	);

	bsk_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.sts(mul_sts), .prod(mul_prod)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (capacity_q != 16'd0) ? S_DELTA : S_IR;
						go_q    <= 1'b1;
					end
				end
				S_DELTA: begin
					if (div_sts.done) begin
						state_q <= S_IR;
						go_q    <= 1'b1;
					end
				end
				S_IR: begin
					if (div_sts.done) begin
						state_q <= S_INNOV;
					end
				end
				S_INNOV: begin
					state_q <= (s4 != 35'd0) ? S_GAIN : S_CMUL;
					go_q    <= 1'b1;
				end
				S_GAIN: begin
					if (div_sts.done) begin
						state_q <= S_CMUL;
						go_q    <= 1'b1;
					end
				end
				S_CMUL: begin
					if (mul_sts.done) begin
						state_q <= S_CDIV;
						go_q    <= 1'b1;
					end
				end
				S_CDIV: begin
					if (div_sts.done) begin
						state_q <= S_PMUL;
						go_q    <= 1'b1;
					end
				end
				S_PMUL: begin
					if (mul_sts.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers loaded along the sequence.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= in_ch.current_ma[15];
			volt_q <= in_ch.voltage_mv;
			mdt_q  <= abs_cur * period_q;
			mrm_q  <= abs_cur * resist_q;
			den_q  <= MS_PER_HOUR_K * capacity_q;
			pp_q   <= pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
			socp_q <= $signed({{(SOCP_W - SOC_W){1'b0}}, soc_q});
		end
		if (state_q == S_DELTA && div_sts.done) begin
			socp_q <= neg_q ? socp_q - {2'd0, div_quo[31:0]}
				: socp_q + {2'd0, div_quo[31:0]};
		end
		if (state_q == S_IR && div_sts.done) begin
			ir_q <= neg_q ? 24'(-div_quo[23:0]) : div_quo[23:0];
		end
		if (state_q == S_INNOV) begin
			y_q  <= y_sat;
			s4_q <= s4;
			g_q  <= '0;
		end
		if (state_q == S_GAIN && div_sts.done) begin
			g_q <= div_quo[MUL_A_W-1:0];
		end
		if (state_q == S_CDIV && div_sts.done) begin
			if (soc_sum[SOCP_W-1]) begin
				soc_n_q <= '0;
				clamp_q <= 1'b1;
			end else if (soc_sum > SOCP_W'(1 << SOC_FRAC_BITS)) begin
				soc_n_q <= SOC_W'(1 << SOC_FRAC_BITS);
				clamp_q <= 1'b1;
			end else begin
				soc_n_q <= soc_sum[SOC_W-1:0];
				clamp_q <= 1'b0;
			end
		end
		if (state_q == S_PMUL && mul_sts.done) begin
			pnew_q <= p_rnd[63:32];
		end
		if (finish) begin
			out_soc_q   <= soc_n_q;
			out_cov_q   <= pnew_q;
			out_y_q     <= y_q;
			out_clamp_q <= clamp_q;
		end
	end

	// Configuration registers and filter state; writing an initial value reloads both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_var_q <= 32'd1678;
			obs_var_q  <= 32'd41943;
			init_soc_q <= SOC_W'(32768);
			init_cov_q <= 32'd1677722;
			period_q   <= 16'd1000;
			capacity_q <= 16'd5000;
			resist_q   <= 16'd50;
			soc_q      <= SOC_W'(32768);
			cov_q      <= 32'd1677722;
		end else if (finish) begin
			soc_q <= soc_n_q;
			cov_q <= pnew_q;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROC_VAR: proc_var_q <= cfg_wdata;
				REG_OBS_VAR:  obs_var_q  <= cfg_wdata;
				REG_INIT_SOC: begin
					init_soc_q <= cfg_wdata[SOC_W-1:0];
					soc_q      <= cfg_wdata[SOC_W-1:0];
					cov_q      <= init_cov_q;
				end
				REG_INIT_COV: begin
					init_cov_q <= cfg_wdata;
					soc_q      <= init_soc_q;
					cov_q      <= cfg_wdata;
				end
				REG_PERIOD:   period_q   <= cfg_wdata[15:0];
				REG_CAPACITY: capacity_q <= cfg_wdata[15:0];
				REG_RESIST:   resist_q   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.estimated_soc = out_soc_q;
	assign out_ch.estimated_cov = out_cov_q;
	assign out_ch.innovation_mv = out_y_q;
	assign out_ch.soc_clamped   = out_clamp_q;

	// A new result word only appears after the finishing step.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result word appeared outside the finishing step");

	// An accepted sample always starts the sequence.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DELTA || state_q == S_IR) && go_q)
		else $error("accepted sample did not start the sequence");

	// The divider is never restarted while it is still iterating.
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider started while busy");

	// The multiplier is never restarted while it is still iterating.
	a_mul_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_sts.busy)
		else $error("multiplier started while busy");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the battery SOC Kalman estimator core: directed samples,
// special cases, configuration sweeps and random traffic with stalls on both sides.
// Depends on bsk_pkg, bsk_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import bsk_pkg::*;

	localparam bit [2:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 300;
	localparam longint SOC_ONE = 64'sd1 << SOC_FRAC_BITS;
	localparam longint unsigned COV_MAX = 64'hFFFF_FFFF;

	// One estimate word as the block reports it.
	typedef struct {
		logic [16:0]        soc;
		logic [31:0]        cov;
		logic signed [17:0] innov;
		logic               clamped;
	} estimate_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	bsk_in_if  in_ch();
	bsk_out_if out_ch();

	battery_soc_kalman_estimator_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the registers and of the filter state.
	longint unsigned mdl_q, mdl_r, mdl_soc0, mdl_cov0, mdl_dt, mdl_cap, mdl_rm;
	longint          mdl_soc;
	longint unsigned mdl_cov;

	estimate_t pending_estimates[$];
	int        mismatches = 0;
	int        words_sent = 0;
	int        words_checked = 0;
	int        clamps_seen = 0;
	int        burst_left = 0;
	bit        hold_req = 0;
	bit        sender_gaps = 1;
	int        rx_mode = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("battery_soc_kalman_estimator_core test failed");
		$finish;
	end

	// Divide with rounding to nearest, ties away from zero.
	function automatic longint round_div(longint n, longint d);
		longint unsigned m, q;
		m = (n < 0) ? longint'(-n) : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void reload_state();
		mdl_soc = mdl_soc0;
		mdl_cov = mdl_cov0;
	endfunction

	function automatic void reset_shadow();
		mdl_q = 1678; mdl_r = 41943; mdl_soc0 = 32768; mdl_cov0 = 1677722;
		mdl_dt = 1000; mdl_cap = 5000; mdl_rm = 50;
		reload_state();
	endfunction

	// One filter step: predict, innovate, correct, clamp.
	function automatic estimate_t kalman_step(logic signed [15:0] cur_in, logic [15:0] volt_in);
		estimate_t e;
		longint cur, socp, pred, y, corr, soc;
		longint unsigned pp, s4, g, pnew;
		cur = cur_in;
		socp = mdl_soc;
		if (mdl_cap != 0) begin
			socp += round_div(cur * longint'(mdl_dt) * SOC_ONE, 64'sd3600000 * longint'(mdl_cap));
		end
		pp = mdl_cov + mdl_q;
		if (pp > COV_MAX) begin
			pp = COV_MAX;
		end
		pred = 3000 + round_div(500 * socp, SOC_ONE) + round_div(cur * longint'(mdl_rm), 1000);
		y = longint'(volt_in) - pred;
		if (y > 131071) begin
			y = 131071;
		end
		if (y < -131072) begin
			y = -131072;
		end
		s4 = pp + 4 * mdl_r;
		g = (s4 != 0) ? (pp << 32) / s4 : 0;
		corr = round_div(longint'(g) * y, 64'sd500 << (32 - SOC_FRAC_BITS));
		soc = socp + corr;
		pnew = (((64'd1 << 32) - g) * pp + (64'd1 << 31)) >> 32;
		e.clamped = 0;
		if (soc < 0) begin
			soc = 0;
			e.clamped = 1;
		end
		if (soc > SOC_ONE) begin
			soc = SOC_ONE;
			e.clamped = 1;
		end
		mdl_soc = soc;
		mdl_cov = pnew & COV_MAX;
		e.soc = soc[16:0];
		e.cov = mdl_cov[31:0];
		e.innov = y[17:0];
		return e;
	endfunction

	// Register write while idle; the shadow copy follows it.
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_PROC_VAR: mdl_q = data;
			REG_OBS_VAR:  mdl_r = data;
			REG_INIT_SOC: begin
				mdl_soc0 = data & 32'h1FFFF;
				reload_state();
			end
			REG_INIT_COV: begin
				mdl_cov0 = data;
				reload_state();
			end
			REG_PERIOD:   mdl_dt = data & 32'hFFFF;
			REG_CAPACITY: mdl_cap = data & 32'hFFFF;
			REG_RESIST:   mdl_rm = data & 32'hFFFF;
			default: ;
		endcase
	endtask

	// Offer one sample word and hold it until accepted; gaps may come between bursts.
	task automatic send_sample(logic signed [15:0] cur, logic [15:0] volt);
		@(negedge clk);
		in_ch.valid <= 1;
		in_ch.current_ma <= cur;
		in_ch.voltage_mv <= volt;
		do @(posedge clk); while (!in_ch.ready);
		pending_estimates.push_back(kalman_step(cur, volt));
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if (sender_gaps && $urandom_range(0, 2) != 0) begin
				@(negedge clk);
				in_ch.valid <= 0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	endtask

	// Wait until every expected word has come, then let the core settle.
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		in_ch.valid <= 0;
		while (pending_estimates.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] q, logic [31:0] r, logic [31:0] soc0,
			logic [31:0] cov0, logic [31:0] dt, logic [31:0] cap, logic [31:0] rm);
		write_reg(REG_PROC_VAR, q);
		write_reg(REG_OBS_VAR, r);
		write_reg(REG_PERIOD, dt);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_RESIST, rm);
		write_reg(REG_INIT_SOC, soc0);
		write_reg(REG_INIT_COV, cov0);
	endtask

	// Mostly plausible samples near the open-circuit curve, some wild ones.
	task automatic random_samples(int n);
		logic signed [15:0] cur;
		logic [15:0]        volt;
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				cur = 16'($urandom);
				volt = 16'($urandom);
			end else begin
				cur = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
				volt = 16'($urandom_range(2800, 3700));
			end
			send_sample(cur, volt);
		end
	endtask

	// Field extremes at the reset configuration.
	task automatic test_directed_extremes();
		send_sample(16'sd0, 16'd3250);
		send_sample(16'sh7FFF, 16'hFFFF);
		send_sample(-16'sd32768, 16'd0);
		send_sample(16'sd1000, 16'd3300);
		send_sample(-16'sd1000, 16'd3200);
		send_sample(16'sh5555, 16'hAAAA);
		send_sample(16'shAAAA, 16'h5555);
		drain();
	endtask

	// Zero capacity, zero variances, large innovation, SOC above one, unused index.
	task automatic test_special_cases();
		set_config(0, 0, 32'h1FFFF, 0, 65535, 0, 65535);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		send_sample(16'sh7FFF, 16'hFFFF);
		send_sample(-16'sd32768, 16'd0);
		send_sample(16'sd0, 16'd3500);
		drain();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0);
		send_sample(16'sh7FFF, 16'd65535);
		send_sample(-16'sd32768, 16'd0);
		send_sample(16'sd100, 16'd3000);
		drain();
		set_config(1678, 0, 65536, 0, 65535, 65535, 0);
		send_sample(16'sd1, 16'd3500);
		send_sample(-16'sd1, 16'd3000);
		drain();
	endtask

	// Several random configurations, each followed by random samples.
	task automatic test_config_sweep();
		repeat (5) begin
			set_config($urandom_range(0, 20000), $urandom_range(0, 200000),
				$urandom, $urandom_range(0, 1 << 26), $urandom_range(1, 60000),
				$urandom_range(100, 65535), $urandom_range(0, 500));
			random_samples(200);
			drain();
		end
	endtask

	// Long receiver hold while the sender keeps offering words.
	task automatic test_backpressure();
		write_reg(REG_INIT_SOC, 32768);
		hold_req = 1;
		sender_gaps = 0;
		random_samples(30);
		sender_gaps = 1;
		drain();
		random_samples(300);
		drain();
	endtask

	// Receiver: a random stall pattern, re-drawn periodically; a hold request first keeps ready low.
	initial begin
		int cyc;
		out_ch.ready = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 0;
				repeat (2000) @(negedge clk);
				hold_req = 0;
			end
			cyc++;
			if (cyc % 256 == 0) begin
				rx_mode = $urandom_range(0, 2);
			end
			case (rx_mode)
				0: out_ch.ready <= 1;
				1: out_ch.ready <= $urandom_range(0, 1);
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Checker: each result word against the oldest expectation.
	always @(posedge clk) begin
		estimate_t exp_e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result word at %0t", $realtime);
				end
			end else begin
				exp_e = pending_estimates.pop_front();
				words_checked++;
				if (out_ch.soc_clamped) begin
					clamps_seen++;
				end
				if (out_ch.estimated_soc !== exp_e.soc || out_ch.estimated_cov !== exp_e.cov
						|| out_ch.innovation_mv !== exp_e.innov
						|| out_ch.soc_clamped !== exp_e.clamped) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch word %0d: soc %0d/%0d cov %0d/%0d innov %0d/%0d clamp %0b/%0b",
							words_checked, exp_e.soc, out_ch.estimated_soc, exp_e.cov,
							out_ch.estimated_cov, exp_e.innov, out_ch.innovation_mv,
							exp_e.clamped, out_ch.soc_clamped);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_PROC_VAR;
		cfg_wdata = 0;
		in_ch.valid = 0;
		in_ch.current_ma = 0;
		in_ch.voltage_mv = 0;
		reset_shadow();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed_extremes();
		test_special_cases();
		test_config_sweep();
		test_backpressure();
		random_samples(60);
		drain();

		if (pending_estimates.size() != 0) begin
			mismatches++;
			$display("%0d expected words never arrived", pending_estimates.size());
		end
		$display("Sent %0d sample words over several configurations, checked %0d results,",
			words_sent, words_checked);
		$display("%0d of them clamped; %0d mismatches.", clamps_seen, mismatches);
		if (mismatches == 0) begin
			$display("battery_soc_kalman_estimator_core test passed");
		end else begin
			$display("battery_soc_kalman_estimator_core test failed");
		end
		$finish;
	end

endmodule
